[hw/rtl/hpcv_pkg.sv]
// Shared types and constants for the HLS pixel colour vote block.
// Colour codes, configuration layout, queue entry formats.
// No dependencies.
`timescale 1ns / 1ps

package hpcv_pkg;

  // Widths and limits
  localparam int unsigned NUM_COLOURS = 6;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned PIX_W       = 8;

  // Counters saturate here
  localparam int unsigned MAX_TILE_PIXELS = 32768;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TILE_PIXELS);

  // Fixed lower hue bounds of the green and blue bands
  localparam logic [PIX_W-1:0] GREEN_HUE_MIN = 8'd30;
  localparam logic [PIX_W-1:0] BLUE_HUE_MIN  = 8'd100;

  // Default queue depths
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned RESULT_DEPTH = 4;

  // Colour codes; NONE marks an unclassified pixel
  typedef enum logic [2:0] {
    COL_WHITE  = 3'd0,
    COL_YELLOW = 3'd1,
    COL_RED    = 3'd2,
    COL_ORANGE = 3'd3,
    COL_GREEN  = 3'd4,
    COL_BLUE   = 3'd5,
    COL_NONE   = 3'd6
  } colour_t;

  // Tie-break order: alphabetical by colour name
  localparam colour_t LETTER_ORDER [NUM_COLOURS] = '{
    COL_BLUE, COL_GREEN, COL_ORANGE, COL_RED, COL_WHITE, COL_YELLOW
  };

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WHITE_SAT_MAX    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_YELLOW_HUE_MIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_YELLOW_HUE_MAX   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_HUE_LOW_MAX  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_HUE_HIGH_MIN = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ORANGE_LIGHT_MIN = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_HUE_MAX    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_HUE_MAX     = 3'd7;

  typedef struct packed {
    logic [CFG_W-1:0] white_sat_max;
    logic [CFG_W-1:0] yellow_hue_min;
    logic [CFG_W-1:0] yellow_hue_max;
    logic [CFG_W-1:0] red_hue_low_max;
    logic [CFG_W-1:0] red_hue_high_min;
    logic [CFG_W-1:0] orange_light_min;
    logic [CFG_W-1:0] green_hue_max;
    logic [CFG_W-1:0] blue_hue_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    white_sat_max:    8'd80,
    yellow_hue_min:   8'd10,
    yellow_hue_max:   8'd30,
    red_hue_low_max:  8'd10,
    red_hue_high_min: 8'd160,
    orange_light_min: 8'd100,
    green_hue_max:    8'd100,
    blue_hue_max:     8'd125
  };

  // Classified pixel between front and back
  typedef struct packed {
    colour_t code;
    logic    last;
  } px_item_t;

  // Tile vote result
  typedef struct packed {
    colour_t          colour;
    logic             found;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

[hw/rtl/hpcv_front.sv]
// Front end: accepts pixels, classifies them and queues the colour codes.
// Depends on hpcv_pkg.
`timescale 1ns / 1ps

module hpcv_front import hpcv_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] hue,
  input  logic [PIX_W-1:0] lightness,
  input  logic [PIX_W-1:0] saturation,
  input  logic             last_pixel,
  output logic             q_valid,
  input  logic             q_pop,
  output px_item_t         q_item
);

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  px_item_t            mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [FILL_W-1:0]   fill;
  colour_t             code;
  logic                wr_en;

  // Threshold tests in priority order
  always_comb begin
    if (saturation <= cfg.white_sat_max) begin
      code = COL_WHITE;
    end else if (hue >= cfg.yellow_hue_min && hue <= cfg.yellow_hue_max) begin
      code = COL_YELLOW;
    end else if (hue <= cfg.red_hue_low_max || hue >= cfg.red_hue_high_min) begin
      code = (lightness < cfg.orange_light_min) ? COL_RED : COL_ORANGE;
    end else if (hue >= GREEN_HUE_MIN && hue <= cfg.green_hue_max) begin
      code = COL_GREEN;
    end else if (hue >= BLUE_HUE_MIN && hue <= cfg.blue_hue_max) begin
      code = COL_BLUE;
    end else begin
      code = COL_NONE;
    end
  end

  assign full    = (fill == FILL_W'(DEPTH));
  assign q_valid = (fill != '0);
  assign wr_en   = push && !full;
  assign q_item  = mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= '{code: code, last: last_pixel};
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, q_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/hpcv_back.sv]
// Back end: per-colour saturating counters, end-of-tile snapshot and vote.
// Depends on hpcv_pkg.
`timescale 1ns / 1ps

module hpcv_back import hpcv_pkg::*; #(
  parameter int unsigned RES_DEPTH = RESULT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  px_item_t                       q_item,
  input  logic [$clog2(RES_DEPTH+1)-1:0] res_fill,
  output logic                           res_push,
  output result_t                        res_data
);

  localparam int unsigned RF_W = $clog2(RES_DEPTH + 1);

  logic [CNT_W-1:0] counts [NUM_COLOURS];
  logic [CNT_W-1:0] counts_next [NUM_COLOURS];
  logic [CNT_W-1:0] snap [NUM_COLOURS];
  logic             snap_valid;
  logic             room;
  logic             tile_end;
  colour_t          best;
  logic [CNT_W-1:0] best_count;

  // A tile end needs a free result slot, counting the vote in flight
  assign room     = ({1'b0, res_fill} + {{RF_W{1'b0}}, snap_valid}) < (RF_W + 1)'(RES_DEPTH);
  assign q_pop    = q_valid && (!q_item.last || room);
  assign tile_end = q_pop && q_item.last;

  // Saturating increment of the matching counter
  always_comb begin
    for (int i = 0; i < NUM_COLOURS; i++) begin
      if (q_item.code == colour_t'(i) && counts[i] != CNT_MAX) begin
        counts_next[i] = counts[i] + 1'b1;
      end else begin
        counts_next[i] = counts[i];
      end
    end
  end

  // Counters: cleared at tile end, final values go to the snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
        counts[i] <= '0;
      end
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= tile_end;
      for (int i = 0; i < NUM_COLOURS; i++) begin
        if (tile_end) begin
          counts[i] <= '0;
        end else if (q_pop) begin
          counts[i] <= counts_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tile_end) begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
        snap[i] <= counts_next[i];
      end
    end
  end

  // Vote: strict greater-than in letter order keeps the earliest on ties
  always_comb begin
    best       = COL_WHITE;
    best_count = '0;
    for (int i = 0; i < NUM_COLOURS; i++) begin
      if (snap[LETTER_ORDER[i]] > best_count) begin
        best_count = snap[LETTER_ORDER[i]];
        best       = LETTER_ORDER[i];
      end
    end
  end

  assign res_push = snap_valid;
  assign res_data = '{colour: best, found: (best_count != '0), count: best_count};

`ifndef SYNTHESIS
  a_pop_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back popped an empty queue");

  a_snap_follows_end: assert property (@(posedge clk) disable iff (rst)
    snap_valid |-> $past(tile_end))
    else $error("vote without a tile end");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    tile_end |=> (counts[0] == '0 && counts[1] == '0 && counts[2] == '0 &&
                  counts[3] == '0 && counts[4] == '0 && counts[5] == '0))
    else $error("counters not cleared after tile end");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    snap_valid |-> best_count <= CNT_MAX)
    else $error("winning count above saturation limit");
`endif

endmodule

[hw/rtl/hpcv_res_fifo.sv]
// Result queue feeding the output side of the block.
// Depends on hpcv_pkg.
`timescale 1ns / 1ps

module hpcv_res_fifo import hpcv_pkg::*; #(
  parameter int unsigned DEPTH = RESULT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  result_t                    wr_data,
  output logic [$clog2(DEPTH+1)-1:0] fill,
  output logic                       empty,
  input  logic                       pop,
  output result_t                    rd_data
);

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             rd_en;

  assign empty   = (fill == '0);
  assign rd_en   = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level; the writer checks room before writing
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    (fill == FILL_W'(DEPTH)) |-> !wr)
    else $error("result written into a full queue");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("result queue fill out of range");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd_en) |=> fill == $past(fill) + 1'b1)
    else $error("result queue fill did not count a write");
`endif

endmodule

[hw/rtl/hls_pixel_colour_vote.sv]
// Top level of the HLS pixel colour vote block: configuration registers,
// front classifier queue, counting back end and result queue.
// Depends on hpcv_pkg, hpcv_front, hpcv_back, hpcv_res_fifo.
//
// Usage:
//   Pixels (hue, lightness, saturation, last_pixel) enter on the push/full
//   queue interface, one per cycle while full is low. Each pixel is sorted
//   into one of six colours and counted, or else left uncounted. The pixel
//   with last_pixel set closes the tile: one result (colour, found,
//   winning_count) then appears on the empty/pop interface and all counters
//   restart from zero. Throughput: one pixel per cycle, sustained while the
//   result queue has room, including tile ends. A tile's result reaches
//   the output (empty low) through the front queue write, then the counter
//   snapshot; the vote settles combinationally into the result queue write.
//   The front queue (QUEUE_DEPTH entries) lets pixels flow in while the
//   counters wait for room in the result queue (RESULT_DEPTH entries).
//   When the receiver stalls, results collect in the result queue; once it
//   is full, tile-end pixels wait in the front queue, which then fills and
//   raises full. Nothing is dropped. The user must write configuration
//   through cfg_wr/cfg_addr/cfg_data only while idle; the block does not
//   enforce this. Reset (rst, synchronous) empties both queues, clears the
//   counters and loads the default thresholds.
`timescale 1ns / 1ps

module hls_pixel_colour_vote import hpcv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P  = QUEUE_DEPTH,
  parameter int unsigned RESULT_DEPTH_P = RESULT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel input
  input  logic                  push,
  output logic                  full,
  input  logic [PIX_W-1:0]      hue,
  input  logic [PIX_W-1:0]      lightness,
  input  logic [PIX_W-1:0]      saturation,
  input  logic                  last_pixel,
  // tile result
  output logic                  empty,
  input  logic                  pop,
  output logic [2:0]            colour,
  output logic                  found,
  output logic [CNT_W-1:0]      winning_count,
  // configuration
  input  logic                  cfg_wr,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int unsigned RF_W = $clog2(RESULT_DEPTH_P + 1);

  cfg_t            cfg;
  logic            q_valid;
  logic            q_pop;
  px_item_t        q_item;
  logic [RF_W-1:0] res_fill;
  logic            res_push;
  result_t         res_in;
  result_t         res_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_WHITE_SAT_MAX:    cfg.white_sat_max    <= cfg_data;
        REG_YELLOW_HUE_MIN:   cfg.yellow_hue_min   <= cfg_data;
        REG_YELLOW_HUE_MAX:   cfg.yellow_hue_max   <= cfg_data;
        REG_RED_HUE_LOW_MAX:  cfg.red_hue_low_max  <= cfg_data;
        REG_RED_HUE_HIGH_MIN: cfg.red_hue_high_min <= cfg_data;
        REG_ORANGE_LIGHT_MIN: cfg.orange_light_min <= cfg_data;
        REG_GREEN_HUE_MAX:    cfg.green_hue_max    <= cfg_data;
        REG_BLUE_HUE_MAX:     cfg.blue_hue_max     <= cfg_data;
        default:              cfg                  <= cfg;
      endcase
    end
  end

  hpcv_front #(
    .DEPTH(QUEUE_DEPTH_P)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .hue        (hue),
    .lightness  (lightness),
    .saturation (saturation),
    .last_pixel (last_pixel),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  hpcv_back #(
    .RES_DEPTH(RESULT_DEPTH_P)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .res_fill (res_fill),
    .res_push (res_push),
    .res_data (res_in)
  );

  hpcv_res_fifo #(
    .DEPTH(RESULT_DEPTH_P)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res_in),
    .fill    (res_fill),
    .empty   (empty),
    .pop     (pop),
    .rd_data (res_out)
  );

  assign colour        = res_out.colour;
  assign found         = res_out.found;
  assign winning_count = res_out.count;

endmodule

[tb/hls_pixel_colour_vote_tb.sv]
// Self-checking testbench for hls_pixel_colour_vote: streams HLS tiles, predicts
// each tile's winning colour and count, and compares every popped result.
// Depends on hpcv_pkg and the hls_pixel_colour_vote RTL.
`timescale 1ns / 1ps

module hls_pixel_colour_vote_tb;
  import hpcv_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT      = 26;
  localparam int PRINT_MAX     = 60;

  // Vote order for ties: alphabetical by colour name
  localparam colour_t TIE_ORDER [NUM_COLOURS] = '{
    COL_BLUE, COL_GREEN, COL_ORANGE, COL_RED, COL_WHITE, COL_YELLOW
  };

  typedef struct packed {
    logic [PIX_W-1:0] h;
    logic [PIX_W-1:0] l;
    logic [PIX_W-1:0] s;
    logic             last;
  } pixel_t;

  // DUT signals
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [PIX_W-1:0]      hue = '0;
  logic [PIX_W-1:0]      lightness = '0;
  logic [PIX_W-1:0]      saturation = '0;
  logic                  last_pixel = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [2:0]            colour;
  logic                  found;
  logic [CNT_W-1:0]      winning_count;
  logic                  cfg_wr = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Shadow thresholds and per-colour tallies
  logic [CFG_W-1:0] thr [8];
  logic [CNT_W-1:0] tally [NUM_COLOURS];
  result_t          tile_votes [$];
  pixel_t           pixel_backlog [$];
  bit               in_flight = 1'b0;
  bit               steady = 1'b0;
  int               errors = 0;
  int               cycles = 0;

  always #5 clk = ~clk;

  hls_pixel_colour_vote uut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .hue           (hue),
    .lightness     (lightness),
    .saturation    (saturation),
    .last_pixel    (last_pixel),
    .empty         (empty),
    .pop           (pop),
    .colour        (colour),
    .found         (found),
    .winning_count (winning_count),
    .cfg_wr        (cfg_wr),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // Threshold tests in priority order
  function automatic colour_t classify_pixel(logic [PIX_W-1:0] h, logic [PIX_W-1:0] l,
                                             logic [PIX_W-1:0] s);
    if (s <= thr[REG_WHITE_SAT_MAX]) return COL_WHITE;
    if (h >= thr[REG_YELLOW_HUE_MIN] && h <= thr[REG_YELLOW_HUE_MAX]) return COL_YELLOW;
    if (h <= thr[REG_RED_HUE_LOW_MAX] || h >= thr[REG_RED_HUE_HIGH_MIN])
      return (l < thr[REG_ORANGE_LIGHT_MIN]) ? COL_RED : COL_ORANGE;
    if (h >= GREEN_HUE_MIN && h <= thr[REG_GREEN_HUE_MAX]) return COL_GREEN;
    if (h >= BLUE_HUE_MIN && h <= thr[REG_BLUE_HUE_MAX]) return COL_BLUE;
    return COL_NONE;
  endfunction

  // Count one accepted pixel; on a tile end, queue the expected vote
  task automatic count_pixel(pixel_t p);
    colour_t c;
    result_t vote;
    c = classify_pixel(p.h, p.l, p.s);
    if (c != COL_NONE && tally[int'(c)] < CNT_MAX) tally[int'(c)]++;
    if (p.last) begin
      vote.colour = COL_WHITE;
      vote.count  = '0;
      for (int i = 0; i < NUM_COLOURS; i++) begin
        if (tally[int'(TIE_ORDER[i])] > vote.count) begin
          vote.count  = tally[int'(TIE_ORDER[i])];
          vote.colour = TIE_ORDER[i];
        end
      end
      vote.found = (vote.count != '0);
      tile_votes.push_back(vote);
      for (int i = 0; i < NUM_COLOURS; i++) tally[i] = '0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (errors < PRINT_MAX)
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Pixel driver: holds each transaction until accepted
  always @(negedge clk) begin
    pixel_t next_px;
    if (rst) begin
      push <= 1'b0;
    end else if (!in_flight) begin
      if (pixel_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_px = pixel_backlog.pop_front();
        hue        <= next_px.h;
        lightness  <= next_px.l;
        saturation <= next_px.s;
        last_pixel <= next_px.last;
        push       <= 1'b1;
        in_flight  = 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result receiver: random pop stalls
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: accept pixels into the predictor, check popped votes
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end else if (!rst) begin
      if (push && !full) begin
        count_pixel('{h: hue, l: lightness, s: saturation, last: last_pixel});
        in_flight = 1'b0;
      end
      if (pop && !empty) begin
        if (tile_votes.size() == 0) begin
          report_mismatch("unexpected result, colour", colour, -1);
        end else begin
          want = tile_votes.pop_front();
          if (colour !== want.colour) report_mismatch("colour", colour, want.colour);
          if (found !== want.found) report_mismatch("found", found, want.found);
          if (winning_count !== want.count)
            report_mismatch("winning_count", winning_count, want.count);
        end
      end
    end
  end

  task automatic add_pixel(logic [PIX_W-1:0] h, logic [PIX_W-1:0] l,
                           logic [PIX_W-1:0] s, logic last);
    pixel_backlog.push_back('{h: h, l: l, s: s, last: last});
  endtask

  // Wait until nothing is pending, then let the pipeline settle
  task automatic drain_and_settle();
    while (pixel_backlog.size() != 0 || in_flight || tile_votes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    thr[idx] = v;
  endtask

  task automatic load_thresholds(logic [CFG_W-1:0] w, logic [CFG_W-1:0] ymin,
                                 logic [CFG_W-1:0] ymax, logic [CFG_W-1:0] rlo,
                                 logic [CFG_W-1:0] rhi, logic [CFG_W-1:0] omin,
                                 logic [CFG_W-1:0] gmax, logic [CFG_W-1:0] bmax);
    write_reg(REG_WHITE_SAT_MAX, w);
    write_reg(REG_YELLOW_HUE_MIN, ymin);
    write_reg(REG_YELLOW_HUE_MAX, ymax);
    write_reg(REG_RED_HUE_LOW_MAX, rlo);
    write_reg(REG_RED_HUE_HIGH_MIN, rhi);
    write_reg(REG_ORANGE_LIGHT_MIN, omin);
    write_reg(REG_GREEN_HUE_MAX, gmax);
    write_reg(REG_BLUE_HUE_MAX, bmax);
    @(negedge clk);
    cfg_wr <= 1'b0;
  endtask

  // Pixel level biased toward the active thresholds and the fixed band edges
  function automatic logic [PIX_W-1:0] pick_level();
    int k;
    logic [PIX_W-1:0] edge_val;
    k = $urandom_range(9);
    if (k < 4) return PIX_W'($urandom_range(255));
    if (k == 4) return '0;
    if (k == 5) return '1;
    case ($urandom_range(9))
      8:       edge_val = GREEN_HUE_MIN;
      9:       edge_val = BLUE_HUE_MIN;
      default: edge_val = thr[$urandom_range(7)];
    endcase
    return edge_val + PIX_W'($urandom_range(2)) - PIX_W'(1);
  endfunction

  // Whole tiles of random pixels, mostly short
  task automatic add_random_tiles(int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(10, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++)
        add_pixel(pick_level(), pick_level(), pick_level(), i == len - 1);
      left -= len;
    end
  endtask

  // Stimulus sequence
  initial begin
    thr[REG_WHITE_SAT_MAX]    = CFG_RESET.white_sat_max;
    thr[REG_YELLOW_HUE_MIN]   = CFG_RESET.yellow_hue_min;
    thr[REG_YELLOW_HUE_MAX]   = CFG_RESET.yellow_hue_max;
    thr[REG_RED_HUE_LOW_MAX]  = CFG_RESET.red_hue_low_max;
    thr[REG_RED_HUE_HIGH_MIN] = CFG_RESET.red_hue_high_min;
    thr[REG_ORANGE_LIGHT_MIN] = CFG_RESET.orange_light_min;
    thr[REG_GREEN_HUE_MAX]    = CFG_RESET.green_hue_max;
    thr[REG_BLUE_HUE_MAX]     = CFG_RESET.blue_hue_max;
    for (int i = 0; i < NUM_COLOURS; i++) tally[i] = '0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed tiles under reset thresholds
    // Nothing classified: found low, colour and count zero
    add_pixel(8'd140, 8'd50, 8'd200, 1'b1);
    // Every class at its band edges; four-way tie goes to blue
    add_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    add_pixel(8'd200, 8'd0,   8'd80,  1'b0);
    add_pixel(8'd10,  8'd0,   8'd81,  1'b0);
    add_pixel(8'd30,  8'd0,   8'd255, 1'b0);
    add_pixel(8'd0,   8'd99,  8'd255, 1'b0);
    add_pixel(8'd255, 8'd100, 8'd255, 1'b0);
    add_pixel(8'd31,  8'd0,   8'd255, 1'b0);
    add_pixel(8'd100, 8'd0,   8'd255, 1'b0);
    add_pixel(8'd101, 8'd0,   8'd255, 1'b0);
    add_pixel(8'd125, 8'd0,   8'd255, 1'b0);
    add_pixel(8'd126, 8'd0,   8'd255, 1'b0);
    add_pixel(8'd159, 8'd0,   8'd255, 1'b1);
    // Pairwise ties: green over white, orange over red, red over white/yellow,
    // white over yellow
    add_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    add_pixel(8'd50,  8'd0,   8'd255, 1'b1);
    add_pixel(8'd170, 8'd10,  8'd255, 1'b0);
    add_pixel(8'd170, 8'd200, 8'd255, 1'b1);
    add_pixel(8'd5,   8'd5,   8'd5,   1'b0);
    add_pixel(8'd20,  8'd5,   8'd90,  1'b0);
    add_pixel(8'd5,   8'd5,   8'd90,  1'b1);
    add_pixel(8'd20,  8'd5,   8'd90,  1'b0);
    add_pixel(8'd20,  8'd5,   8'd5,   1'b1);
    // All fields at maximum
    add_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    drain_and_settle();

    // Random phases over several threshold settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_thresholds(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        1: load_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        // crossed and empty bands
        2: load_thresholds(8'd0, 8'd200, 8'd50, 8'd0, 8'd255, 8'd128, 8'd20, 8'd90);
        3: load_thresholds(CFG_RESET.white_sat_max, CFG_RESET.yellow_hue_min,
                           CFG_RESET.yellow_hue_max, CFG_RESET.red_hue_low_max,
                           CFG_RESET.red_hue_high_min, CFG_RESET.orange_light_min,
                           CFG_RESET.green_hue_max, CFG_RESET.blue_hue_max);
        default: load_thresholds(CFG_W'($urandom_range(120)), CFG_W'($urandom_range(255)),
                                 CFG_W'($urandom_range(255)), CFG_W'($urandom_range(255)),
                                 CFG_W'($urandom_range(255)), CFG_W'($urandom_range(255)),
                                 CFG_W'($urandom_range(255)), CFG_W'($urandom_range(255)));
      endcase
      steady = (ph == 5);
      add_random_tiles(210);
      drain_and_settle();
      steady = 1'b0;
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/hpcv_pkg.sv
hw/rtl/hpcv_front.sv
hw/rtl/hpcv_back.sv
hw/rtl/hpcv_res_fifo.sv
hw/rtl/hls_pixel_colour_vote.sv
tb/hls_pixel_colour_vote_tb.sv
